@@ rtl/gtab_pkg.sv @@
// Package for the gate triggered alarm blinker.
// Holds register indexes, reset values, widths and the shared struct types.
// No dependencies.
`default_nettype none

package gtab_pkg;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CntW    = 17;

  localparam logic [CfgW-1:0] BlinkPeriodRst  = 16'd500;
  localparam logic [CfgW-1:0] GateHoldoffRst  = 16'd500;
  localparam logic [CfgW-1:0] AlarmTimeoutRst = 16'd30000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BLINK_PERIOD  = 2'd0,
    REG_GATE_HOLDOFF  = 2'd1,
    REG_ALARM_TIMEOUT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] blink_period;
    logic [CfgW-1:0] gate_holdoff;
    logic [CfgW-1:0] alarm_timeout;
  } cfg_t;

  typedef struct packed {
    logic alarm_on;
    logic led_b;
    logic led_a;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/gtab_cfg_regs.sv @@
// Configuration register file: blink period, gate hold-off, alarm timeout.
// Depends on gtab_pkg.
`default_nettype none

module gtab_cfg_regs
  import gtab_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BLINK_PERIOD:  cfg_d.blink_period  = cfg_data_i;
        REG_GATE_HOLDOFF:  cfg_d.gate_holdoff  = cfg_data_i;
        REG_ALARM_TIMEOUT: cfg_d.alarm_timeout = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_period  <= BlinkPeriodRst;
      cfg_q.gate_holdoff  <= GateHoldoffRst;
      cfg_q.alarm_timeout <= AlarmTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/gtab_tick_core.sv @@
// Per-tick state update: alarm flag, blink phase, LED latches, elapsed counters.
// Depends on gtab_pkg.
`default_nettype none

module gtab_tick_core
  import gtab_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic tick_i,
  input  wire logic gate_a_i,
  input  wire logic gate_b_i,
  input  cfg_t      cfg_i,
  output result_t   res_o
);

  localparam logic [CntW-1:0] CntMax = '1;

  logic            alarm_q, alarm_d;
  logic            phase_q, phase_d;
  logic            led_a_q, led_a_d;
  logic            led_b_q, led_b_d;
  logic [CntW-1:0] since_blink_q, since_blink_d;
  logic [CntW-1:0] since_gate_q, since_gate_d;

  logic [CntW-1:0] sb_inc, sg_inc;
  logic            blink_over, hit, toggle;

  always_comb begin
    sb_inc     = (since_blink_q == CntMax) ? CntMax : since_blink_q + 1'b1;
    sg_inc     = (since_gate_q == CntMax) ? CntMax : since_gate_q + 1'b1;
    blink_over = sb_inc > {1'b0, cfg_i.blink_period};
    hit        = !gate_a_i || !gate_b_i;
    toggle     = hit && !(sg_inc < {1'b0, cfg_i.gate_holdoff});

    alarm_d       = alarm_q;
    phase_d       = phase_q;
    led_a_d       = led_a_q;
    led_b_d       = led_b_q;
    since_blink_d = sb_inc;
    since_gate_d  = hit ? '0 : sg_inc;

    if (alarm_q) begin
      led_a_d = !phase_q;
      led_b_d = phase_q;
      if (blink_over) begin
        since_blink_d = '0;
        phase_d       = !phase_q;
      end
    end else if (blink_over) begin
      led_a_d = 1'b0;
      led_b_d = 1'b0;
    end

    if (toggle) begin
      alarm_d = !alarm_q;
    end
    if (since_gate_d > {1'b0, cfg_i.alarm_timeout}) begin
      alarm_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q       <= 1'b0;
      phase_q       <= 1'b0;
      led_a_q       <= 1'b0;
      led_b_q       <= 1'b0;
      since_blink_q <= '0;
      since_gate_q  <= '0;
    end else if (tick_i) begin
      alarm_q       <= alarm_d;
      phase_q       <= phase_d;
      led_a_q       <= led_a_d;
      led_b_q       <= led_b_d;
      since_blink_q <= since_blink_d;
      since_gate_q  <= since_gate_d;
    end
  end

  assign res_o.led_a    = led_a_d;
  assign res_o.led_b    = led_b_d;
  assign res_o.alarm_on = alarm_d;

endmodule

`default_nettype wire

@@ rtl/gtab_out_reg.sv @@
// Result register on the master side; loads a beat while the previous one drains.
// Depends on gtab_pkg.
`default_nettype none

module gtab_out_reg
  import gtab_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  result_t   res_i,
  output logic      space_o,
  output logic      valid_o,
  input  wire logic ready_i,
  output result_t   res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

@@ rtl/gate_triggered_alarm_blinker.sv @@
// Top level of the gate triggered alarm blinker: one input beat per tick, one result beat.
// Depends on gtab_pkg, gtab_cfg_regs, gtab_tick_core and gtab_out_reg.
//
// Each input beat is one tick and yields one result beat in the next cycle. A new beat
// is taken in every cycle while the result register is empty or being drained, so the
// sustained rate is one tick per clock; the single result register sets that figure.
// Register writes take effect from the next tick. The config port is always ready.
`default_nettype none

module gate_triggered_alarm_blinker
  import gtab_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,   // [0] gate_a, [1] gate_b
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [7:0]              m_axis_tdata,   // [0] led_a, [1] led_b, [2] alarm_on
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  cfg_t    cfg;
  result_t res_next, res_out;
  logic    space, tick;

  gtab_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign s_axis_tready = space;
  assign tick          = s_axis_tvalid && space;

  gtab_tick_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick),
    .gate_a_i (s_axis_tdata[0]),
    .gate_b_i (s_axis_tdata[1]),
    .cfg_i    (cfg),
    .res_o    (res_next)
  );

  gtab_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (tick),
    .res_i   (res_next),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_out)
  );

  assign m_axis_tdata = {5'b0, res_out.alarm_on, res_out.led_b, res_out.led_a};

endmodule

`default_nettype wire

@@ rtl/gtab_checker.sv @@
// Port-level checks for the gate triggered alarm blinker, bound to the top level.
// Depends on gtab_pkg.
`default_nettype none

module gtab_checker
  import gtab_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [7:0] s_axis_tdata,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata[7] || !s_axis_tdata[7]);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> m_axis_tvalid)
    else $error("accepted tick gave no result beat");

  a_ready_tracks_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow result register room");

  a_leds_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("both LEDs lit");

endmodule

bind gate_triggered_alarm_blinker gtab_checker u_gtab_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ verif/gtab_tick_checker.sv @@
// Checker for the gate triggered alarm blinker: follows the tick, result and register
// channels, predicts every result beat and compares it. Depends on gtab_pkg.
module gtab_tick_checker
  import gtab_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               tick_valid_i,
  input  wire logic               tick_ready_i,
  input  wire logic [7:0]         tick_data_i,   // [0] gate_a, [1] gate_b
  input  wire logic               res_valid_i,
  input  wire logic               res_ready_i,
  input  wire logic [7:0]         res_data_i,    // [0] led_a, [1] led_b, [2] alarm_on
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  output int unsigned             fails_o,
  output int unsigned             pending_o
);

  localparam logic [CntW-1:0] CntSat = {CntW{1'b1}};

  cfg_t            regs;
  logic            alarm;
  logic            phase;
  logic            led_a;
  logic            led_b;
  logic [CntW-1:0] since_blink;
  logic [CntW-1:0] since_gate;
  result_t         due_results[$];
  int unsigned     fails = 0;
  int unsigned     pending = 0;

  assign fails_o   = fails;
  assign pending_o = pending;

  task automatic advance_tick(input logic gate_a, input logic gate_b);
    logic hit;
    if (since_blink != CntSat) since_blink++;
    if (since_gate != CntSat) since_gate++;
    if (alarm) begin
      led_a = !phase;
      led_b = phase;
      if (since_blink > regs.blink_period) begin
        since_blink = '0;
        phase = !phase;
      end
    end else if (since_blink > regs.blink_period) begin
      led_a = 1'b0;
      led_b = 1'b0;
    end
    hit = !gate_a || !gate_b;
    if (hit) begin
      if (since_gate < regs.gate_holdoff) hit = 1'b0;
      since_gate = '0;
    end
    if (hit) alarm = !alarm;
    if (since_gate > regs.alarm_timeout) alarm = 1'b0;
    due_results.push_back('{alarm_on: alarm, led_b: led_b, led_a: led_a});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      regs = '{blink_period: BlinkPeriodRst, gate_holdoff: GateHoldoffRst,
               alarm_timeout: AlarmTimeoutRst};
      alarm       = 1'b0;
      phase       = 1'b0;
      led_a       = 1'b0;
      led_b       = 1'b0;
      since_blink = '0;
      since_gate  = '0;
      due_results.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (due_results.size() == 0) begin
          fails++;
          $display("%0t: result beat %h with no tick waiting", $time, res_data_i);
        end else begin
          want = due_results.pop_front();
          if (res_data_i[0] !== want.led_a || res_data_i[1] !== want.led_b ||
              res_data_i[2] !== want.alarm_on || res_data_i[7:3] !== '0) begin
            fails++;
            $display("%0t: expected led_a=%b led_b=%b alarm_on=%b pad=00, got %h",
                     $time, want.led_a, want.led_b, want.alarm_on, res_data_i);
          end
        end
      end
      if (tick_valid_i && tick_ready_i) advance_tick(tick_data_i[0], tick_data_i[1]);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_BLINK_PERIOD:  regs.blink_period  = cfg_data_i;
          REG_GATE_HOLDOFF:  regs.gate_holdoff  = cfg_data_i;
          REG_ALARM_TIMEOUT: regs.alarm_timeout = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending = due_results.size();
  end

endmodule

@@ verif/gate_triggered_alarm_blinker_tb.sv @@
// Testbench top for the gate triggered alarm blinker: drives ticks, register writes and
// result back-pressure, and reports the verdict. Depends on gtab_pkg, gtab_tick_checker
// and the block itself.
module gate_triggered_alarm_blinker_tb;
  import gtab_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare  = 2'd3;
  localparam int unsigned        IdleLimit = 2000;
  localparam int unsigned        LongHold  = 400;

  logic               clk;
  logic               rst_n;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [7:0]         m_axis_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;
  int unsigned        fails;
  int unsigned        pending;
  int unsigned        idle_cycles = 0;
  int unsigned        tx_calm = 0;
  int unsigned        rx_calm = 0;

  gate_triggered_alarm_blinker uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  gtab_tick_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .tick_valid_i (s_axis_tvalid),
    .tick_ready_i (s_axis_tready),
    .tick_data_i  (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fails_o      (fails),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(149) == 0) calm = $urandom_range(120, 40);
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 97) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  task automatic send_tick(input logic gate_a, input logic gate_b);
    int unsigned gap;
    logic [5:0]  junk;
    gap  = pick_gap(tx_calm);
    junk = 6'($urandom);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {junk, gate_b, gate_a};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_quiet(input int unsigned count);
    repeat (count) send_tick(1'b1, 1'b1);
  endtask

  // drain the block, then write all registers and the spare index
  task automatic load_regs(input logic [CfgW-1:0] blink, input logic [CfgW-1:0] pause,
                           input logic [CfgW-1:0] timeout);
    logic [CfgIdxW-1:0] order [4];
    logic [CfgW-1:0]    value [4];
    order = '{REG_BLINK_PERIOD, REG_GATE_HOLDOFF, REG_ALARM_TIMEOUT, RegSpare};
    value = '{blink, pause, timeout, CfgW'($urandom)};
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (3) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= value[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_side
    int unsigned stall;
    int unsigned beats;
    int unsigned next_hold;
    stall         = 0;
    beats         = 0;
    next_hold     = 300;
    m_axis_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) beats++;
      if (stall != 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (beats >= next_hold) begin
        next_hold += 5000;
        stall = LongHold - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall = pick_gap(rx_calm);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned rate;
    logic [CfgW-1:0] blink;
    logic [CfgW-1:0] pause;
    logic [CfgW-1:0] timeout;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_BLINK_PERIOD;
    cfg_data      = '0;
    rst_n         = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // interruptions right after reset fall inside the trigger pause
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);

    load_regs(16'd2, 16'd0, 16'd6);
    send_tick(1'b0, 1'b1);
    send_quiet(4);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_quiet(8);

    load_regs(16'd0, 16'd3, 16'd0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_quiet(3);
    send_tick(1'b0, 1'b1);
    send_quiet(1);

    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(5))
        0:       blink = '0;
        1:       blink = '1;
        5:       blink = CfgW'($urandom);
        default: blink = CfgW'($urandom_range(12));
      endcase
      case ($urandom_range(4))
        0:       pause = '0;
        1:       pause = '1;
        default: pause = CfgW'($urandom_range(10));
      endcase
      case ($urandom_range(4))
        0:       timeout = '0;
        1:       timeout = '1;
        2:       timeout = CfgW'($urandom);
        default: timeout = CfgW'($urandom_range(80));
      endcase
      load_regs(blink, pause, timeout);
      rate = $urandom_range(30, 2);
      repeat (120) begin
        if ($urandom_range(rate - 1) == 0) begin
          case ($urandom_range(2))
            0:       send_tick(1'b0, 1'b1);
            1:       send_tick(1'b1, 1'b0);
            default: send_tick(1'b0, 1'b0);
          endcase
        end else begin
          send_tick(1'b1, 1'b1);
        end
      end
    end

    // hold the alarm under the longest timeout while the phase blinks, then toggle it off
    load_regs(16'd3, 16'd0, 16'hFFFF);
    send_tick(1'b0, 1'b1);
    send_quiet(10);
    send_tick(1'b0, 1'b0);
    send_quiet(5);

    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ gate_triggered_alarm_blinker.f @@
rtl/gtab_pkg.sv
rtl/gtab_cfg_regs.sv
rtl/gtab_tick_core.sv
rtl/gtab_out_reg.sv
rtl/gate_triggered_alarm_blinker.sv
rtl/gtab_checker.sv
verif/gtab_tick_checker.sv
verif/gate_triggered_alarm_blinker_tb.sv
